@@ rtl/core/utf8_turkish_search_fold_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Turkish search-key folder
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef UTF8_TURKISH_SEARCH_FOLD_MACROS_SVH
`define UTF8_TURKISH_SEARCH_FOLD_MACROS_SVH

// Same-cycle implication.
`define UTSF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("utsf: same-cycle check failed");

// Next-cycle implication.
`define UTSF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("utsf: next-cycle check failed");

`endif

@@ rtl/core/utsf_pkg.sv @@
// ----------------------------------------------------------------------------
// Turkish search-key folder package
// Byte constants, the result slot type and the small decode functions.
// ----------------------------------------------------------------------------
`default_nettype none

package utsf_pkg;

   localparam logic [7:0] ASCII_SPACE = 8'h20;
   localparam logic [7:0] ASCII_TAB   = 8'h09;
   localparam logic [7:0] ASCII_LF    = 8'h0A;
   localparam logic [7:0] ASCII_CR    = 8'h0D;
   localparam logic [7:0] ASCII_UC_A  = 8'h41;
   localparam logic [7:0] ASCII_UC_Z  = 8'h5A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   localparam logic [7:0] LEAD_C3 = 8'hC3;
   localparam logic [7:0] LEAD_C4 = 8'hC4;
   localparam logic [7:0] LEAD_C5 = 8'hC5;

   localparam logic [7:0] LETTER_C = 8'h63;
   localparam logic [7:0] LETTER_G = 8'h67;
   localparam logic [7:0] LETTER_I = 8'h69;
   localparam logic [7:0] LETTER_O = 8'h6F;
   localparam logic [7:0] LETTER_S = 8'h73;
   localparam logic [7:0] LETTER_U = 8'h75;
   localparam logic [7:0] NO_LETTER = 8'h00;

   // Number of result slots one input byte can fill.
   localparam int unsigned SLOT_COUNT = 3;

   // One result item.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       last_of_key;
   } slot_type;

   // Maps a held lead and its second byte to the folded ASCII letter,
   // or NO_LETTER when the pair is not one of the Turkish letters.
   function automatic logic [7:0] turkish_letter(input logic [7:0] lead,
                                                 input logic [7:0] tail);
      logic [7:0] letter;
      letter = NO_LETTER;
      case (lead)
         LEAD_C3: begin
            if (tail == 8'h87 || tail == 8'hA7) letter = LETTER_C;
            if (tail == 8'h96 || tail == 8'hB6) letter = LETTER_O;
            if (tail == 8'h9C || tail == 8'hBC) letter = LETTER_U;
         end
         LEAD_C4: begin
            if (tail == 8'h9E || tail == 8'h9F) letter = LETTER_G;
            if (tail == 8'hB0 || tail == 8'hB1) letter = LETTER_I;
         end
         LEAD_C5: begin
            if (tail == 8'h9E || tail == 8'h9F) letter = LETTER_S;
         end
         default: begin
            letter = NO_LETTER;
         end
      endcase
      return letter;
   endfunction

   // Continuation bytes that follow a lead byte; invalid leads count as
   // one-byte characters.
   function automatic logic [1:0] tail_count(input logic [7:0] b);
      logic [1:0] n;
      n = 2'd0;
      if (b[7:5] == 3'b110) n = 2'd1;
      if (b[7:4] == 4'b1110) n = 2'd2;
      if (b[7:3] == 5'b11110) n = 2'd3;
      return n;
   endfunction

   function automatic logic is_blank(input logic [7:0] b);
      return (b == ASCII_SPACE) || (b == ASCII_TAB) ||
             (b == ASCII_LF) || (b == ASCII_CR);
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/utsf_req_if.sv @@
// ----------------------------------------------------------------------------
// Input byte channel
// Valid/ready channel carrying one UTF-8 byte and its end-of-string mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface utsf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_string;

   modport source (output valid, output in_byte, output end_of_string, input ready);
   modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

`default_nettype wire

@@ rtl/core/utsf_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Folded key channel
// Valid/ready channel carrying one folded byte or an end-only marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface utsf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       has_byte;
   logic       last_of_key;

   modport source (output valid, output out_byte, output has_byte,
                   output last_of_key, input ready);
   modport sink   (input valid, input out_byte, input has_byte,
                   input last_of_key, output ready);
endinterface

`default_nettype wire

@@ rtl/core/utf8_turkish_search_fold.sv @@
// ----------------------------------------------------------------------------
// UTF-8 Turkish search-key folder
// Folds a UTF-8 byte stream into a lower-case ASCII search key with
// collapsed whitespace.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Payload                               Handshake
//   req_ch   in   in_byte[7:0], end_of_string           valid / ready
//   rsp_ch   out  out_byte[7:0], has_byte, last_of_key  valid / ready
//
// A byte is decoded in the cycle of its transfer and its results (up to
// three) are written into a three-slot result buffer that drains one per cycle
// while rsp_ch is ready. Bytes giving one result or none stream at one per
// cycle when rsp_ch is ready; a byte giving more holds the next one back.
// The next byte is taken while the last buffered result is being transferred.
// Synchronous reset clears the decode state and empties the buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_turkish_search_fold (
   input  wire        clock,
   input  wire        reset,
   utsf_req_if.sink   req_ch,
   utsf_rsp_if.source rsp_ch
);

   `include "utf8_turkish_search_fold_macros.svh"

   // Decode state.
   logic [7:0] held_lead_ff,      held_lead_in;
   logic       lead_pending_ff,   lead_pending_in;
   logic [1:0] raw_left_ff,       raw_left_in;
   logic       space_pending_ff,  space_pending_in;
   logic       emitted_any_ff,    emitted_any_in;

   // Result buffer: slot 0 is shown on rsp_ch.
   utsf_pkg::slot_type slot_ff [utsf_pkg::SLOT_COUNT];
   utsf_pkg::slot_type slot_in [utsf_pkg::SLOT_COUNT];
   logic [1:0]         count_ff;
   logic [1:0]         count_in;

   logic       req_xfer;
   logic       rsp_xfer;
   logic [7:0] b;
   logic       eos;
   logic [7:0] letter;
   logic       b1_valid;
   logic [7:0] b1;
   logic       b2_valid;
   logic [7:0] b2;
   logic       space_out;
   utsf_pkg::slot_type cand  [utsf_pkg::SLOT_COUNT];
   logic               cand_valid [utsf_pkg::SLOT_COUNT];
   logic [1:0]         fill;

   assign b   = req_ch.in_byte;
   assign eos = req_ch.end_of_string;

   // Handshake: take a byte when the buffer is empty or about to be.
   assign rsp_ch.valid = (count_ff != 2'd0);
   assign rsp_xfer     = rsp_ch.valid && rsp_ch.ready;
   assign req_ch.ready = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_ch.ready);
   assign req_xfer     = req_ch.valid && req_ch.ready;

   assign rsp_ch.out_byte    = slot_ff[0].out_byte;
   assign rsp_ch.has_byte    = slot_ff[0].has_byte;
   assign rsp_ch.last_of_key = slot_ff[0].last_of_key;

   assign letter = utsf_pkg::turkish_letter(held_lead_ff, b);

   // Byte decode: up to two bytes plus a pending space.
   always_comb begin
      b1_valid         = 1'b0;
      b1               = b;
      b2_valid         = 1'b0;
      b2               = b;
      held_lead_in     = held_lead_ff;
      lead_pending_in  = lead_pending_ff;
      raw_left_in      = raw_left_ff;
      space_pending_in = space_pending_ff;
      if (lead_pending_ff) begin
         lead_pending_in = 1'b0;
         held_lead_in    = 8'h00;
         b1_valid        = 1'b1;
         if (letter != utsf_pkg::NO_LETTER) begin
            b1 = letter;
         end else begin
            b1       = held_lead_ff;
            b2_valid = !(eos && (b == utsf_pkg::ASCII_SPACE));
         end
      end else if (raw_left_ff != 2'd0) begin
         b1_valid    = !(eos && (b == utsf_pkg::ASCII_SPACE));
         raw_left_in = raw_left_ff - 2'd1;
      end else if (!b[7]) begin
         if (utsf_pkg::is_blank(b)) begin
            if (emitted_any_ff) begin
               space_pending_in = 1'b1;
            end
         end else begin
            b1_valid = 1'b1;
            if (b >= utsf_pkg::ASCII_UC_A && b <= utsf_pkg::ASCII_UC_Z) begin
               b1 = b + utsf_pkg::CASE_OFFSET;
            end
         end
      end else if ((b == utsf_pkg::LEAD_C3 || b == utsf_pkg::LEAD_C4 ||
                    b == utsf_pkg::LEAD_C5) && !eos) begin
         held_lead_in    = b;
         lead_pending_in = 1'b1;
      end else begin
         b1_valid    = 1'b1;
         raw_left_in = eos ? 2'd0 : utsf_pkg::tail_count(b);
      end

      // A held-back space goes out ahead of the next emitted byte.
      space_out = space_pending_ff && b1_valid;
      if (space_out) begin
         space_pending_in = 1'b0;
      end
      emitted_any_in = emitted_any_ff || b1_valid;

      // The end of a string returns the decode state to its reset values.
      if (eos) begin
         held_lead_in     = 8'h00;
         lead_pending_in  = 1'b0;
         raw_left_in      = 2'd0;
         space_pending_in = 1'b0;
         emitted_any_in   = 1'b0;
      end
   end

   // Pack the candidate results in order and mark the last one.
   always_comb begin
      cand[0]       = '{out_byte: utsf_pkg::ASCII_SPACE, has_byte: 1'b1, last_of_key: 1'b0};
      cand[1]       = '{out_byte: b1, has_byte: 1'b1, last_of_key: 1'b0};
      cand[2]       = '{out_byte: b2, has_byte: 1'b1, last_of_key: 1'b0};
      cand_valid[0] = space_out;
      cand_valid[1] = b1_valid;
      cand_valid[2] = b2_valid;
      fill          = 2'd0;
      for (int i = 0; i < utsf_pkg::SLOT_COUNT; i++) begin
         slot_in[i] = '{out_byte: 8'h00, has_byte: 1'b0, last_of_key: 1'b0};
      end
      for (int i = 0; i < utsf_pkg::SLOT_COUNT; i++) begin
         if (cand_valid[i]) begin
            slot_in[fill] = cand[i];
            fill          = fill + 2'd1;
         end
      end
      if (eos) begin
         if (fill == 2'd0) begin
            slot_in[0] = '{out_byte: 8'h00, has_byte: 1'b0, last_of_key: 1'b1};
            fill       = 2'd1;
         end else begin
            slot_in[fill - 2'd1].last_of_key = 1'b1;
         end
      end
      count_in = fill;
   end

   // Decode state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_lead_ff     <= 8'h00;
         lead_pending_ff  <= 1'b0;
         raw_left_ff      <= 2'd0;
         space_pending_ff <= 1'b0;
         emitted_any_ff   <= 1'b0;
      end else if (req_xfer) begin
         held_lead_ff     <= held_lead_in;
         lead_pending_ff  <= lead_pending_in;
         raw_left_ff      <= raw_left_in;
         space_pending_ff <= space_pending_in;
         emitted_any_ff   <= emitted_any_in;
      end
   end

   // Result buffer: load on an input transfer, else shift on an output transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else if (req_xfer) begin
         count_ff <= count_in;
      end else if (rsp_xfer) begin
         count_ff <= count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         for (int i = 0; i < utsf_pkg::SLOT_COUNT; i++) begin
            slot_ff[i] <= slot_in[i];
         end
      end else if (rsp_xfer) begin
         slot_ff[0] <= slot_ff[1];
         slot_ff[1] <= slot_ff[2];
      end
   end

   // An end-only marker is always the last result and stands alone.
   `UTSF_ASSERT_NOW(a_marker_alone, clock, reset,
      rsp_ch.valid && !rsp_ch.has_byte, rsp_ch.last_of_key && (count_ff == 2'd1))

   // A string end leaves the decode state cleared.
   `UTSF_ASSERT_NEXT(a_eos_clears, clock, reset,
      req_xfer && eos,
      !lead_pending_ff && (raw_left_ff == 2'd0) && !space_pending_ff && !emitted_any_ff)

   // Only the three Turkish lead bytes are ever held.
   `UTSF_ASSERT_NOW(a_held_lead_kind, clock, reset,
      lead_pending_ff,
      (held_lead_ff == utsf_pkg::LEAD_C3) || (held_lead_ff == utsf_pkg::LEAD_C4) ||
      (held_lead_ff == utsf_pkg::LEAD_C5))

   // A held lead and raw continuation bytes never overlap.
   `UTSF_ASSERT_NOW(a_lead_raw_exclusive, clock, reset,
      lead_pending_ff, raw_left_ff == 2'd0)

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// Testbench for the UTF-8 Turkish search-key folder
// Sends directed strings and random UTF-8 text through the byte channel,
// predicts the folded key byte by byte, and checks every result transfer
// in order under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb;

   logic clock;
   logic reset;

   utsf_req_if req_ch ();
   utsf_rsp_if rsp_ch ();

   utf8_turkish_search_fold dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Idling percentages for the current phase.
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;

   // Predictor state, one copy of the block's decode state.
   logic [7:0] held_byte;
   logic       lead_wait;
   logic [1:0] raw_left;
   logic       space_wait;
   logic       any_emitted;

   // Folded key results still to arrive, oldest first.
   utsf_pkg::slot_type folded_q[$];

   // Bytes of the string being built for sending.
   logic [7:0] text_q[$];

   int unsigned mismatch_count;
   int unsigned byte_count;
   int unsigned string_count;
   int unsigned result_count;

   utsf_pkg::slot_type got_slot;
   utsf_pkg::slot_type want_slot;

   // Clock with a period of 2.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver stalls are chosen each cycle.
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // ---------------------------------------------------------------------
   // Queue helpers
   // ---------------------------------------------------------------------

   // Appends one expected result at the young end of the queue.
   task automatic add_result(input utsf_pkg::slot_type s);
      folded_q.insert(folded_q.size(), s);
   endtask

   // Appends one byte to the string being built.
   task automatic add_text(input logic [7:0] b);
      text_q.insert(text_q.size(), b);
   endtask

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   function automatic utsf_pkg::slot_type data_slot(input logic [7:0] b);
      utsf_pkg::slot_type s;
      s.out_byte    = b;
      s.has_byte    = 1'b1;
      s.last_of_key = 1'b0;
      return s;
   endfunction

   // Folded ASCII letter for a Turkish two-byte pair, NO_LETTER otherwise.
   function automatic logic [7:0] fold_letter(input logic [7:0] lead,
                                              input logic [7:0] tail);
      logic [7:0] letter;
      letter = utsf_pkg::NO_LETTER;
      if (lead == utsf_pkg::LEAD_C3) begin
         case (tail)
            8'h87, 8'hA7: letter = utsf_pkg::LETTER_C;
            8'h96, 8'hB6: letter = utsf_pkg::LETTER_O;
            8'h9C, 8'hBC: letter = utsf_pkg::LETTER_U;
            default:      letter = utsf_pkg::NO_LETTER;
         endcase
      end else if (lead == utsf_pkg::LEAD_C4) begin
         case (tail)
            8'h9E, 8'h9F: letter = utsf_pkg::LETTER_G;
            8'hB0, 8'hB1: letter = utsf_pkg::LETTER_I;
            default:      letter = utsf_pkg::NO_LETTER;
         endcase
      end else if (lead == utsf_pkg::LEAD_C5) begin
         if (tail == 8'h9E || tail == 8'h9F) letter = utsf_pkg::LETTER_S;
      end
      return letter;
   endfunction

   // Continuation bytes that a lead byte announces.
   function automatic logic [1:0] raw_tail_len(input logic [7:0] b);
      logic [1:0] n;
      casez (b)
         8'b110?_????: n = 2'd1;
         8'b1110_????: n = 2'd2;
         8'b1111_0???: n = 2'd3;
         default:      n = 2'd0;
      endcase
      return n;
   endfunction

   function automatic logic blank_byte(input logic [7:0] b);
      return b == utsf_pkg::ASCII_SPACE || b == utsf_pkg::ASCII_TAB ||
             b == utsf_pkg::ASCII_LF || b == utsf_pkg::ASCII_CR;
   endfunction

   // A byte of the key, preceded by the collapsed space if one waits.
   task automatic put_folded(input logic [7:0] b);
      if (space_wait) begin
         add_result(data_slot(utsf_pkg::ASCII_SPACE));
         space_wait = 1'b0;
      end
      add_result(data_slot(b));
      any_emitted = 1'b1;
   endtask

   // A raw byte; a space on the final byte is a trailing space and vanishes.
   task automatic put_raw(input logic [7:0] b, input logic eos);
      if (!(eos && b == utsf_pkg::ASCII_SPACE)) put_folded(b);
   endtask

   task automatic clear_fold_state();
      held_byte   = 8'h00;
      lead_wait   = 1'b0;
      raw_left    = 2'd0;
      space_wait  = 1'b0;
      any_emitted = 1'b0;
   endtask

   // Works out the results that one accepted byte causes.
   task automatic fold_byte(input logic [7:0] b, input logic eos);
      int                 first;
      logic [7:0]         letter;
      utsf_pkg::slot_type tail_slot;
      first = folded_q.size();
      if (lead_wait) begin
         // Second byte of a held lead: a Turkish letter or both bytes raw.
         letter    = fold_letter(held_byte, b);
         lead_wait = 1'b0;
         if (letter != utsf_pkg::NO_LETTER) begin
            put_folded(letter);
         end else begin
            put_folded(held_byte);
            put_raw(b, eos);
         end
         held_byte = 8'h00;
      end else if (raw_left != 2'd0) begin
         // Inside a raw multibyte character nothing is folded.
         put_raw(b, eos);
         raw_left = raw_left - 2'd1;
      end else if (!b[7]) begin
         if (blank_byte(b)) begin
            if (any_emitted) space_wait = 1'b1;
         end else if (b >= utsf_pkg::ASCII_UC_A && b <= utsf_pkg::ASCII_UC_Z) begin
            put_folded(b + utsf_pkg::CASE_OFFSET);
         end else begin
            put_folded(b);
         end
      end else if ((b == utsf_pkg::LEAD_C3 || b == utsf_pkg::LEAD_C4 ||
                    b == utsf_pkg::LEAD_C5) && !eos) begin
         held_byte = b;
         lead_wait = 1'b1;
      end else begin
         // Other leads and stray bytes pass raw; a lead at the end holds nothing.
         put_folded(b);
         raw_left = eos ? 2'd0 : raw_tail_len(b);
      end

      // The end of the string marks its last result, adding one if needed.
      if (eos) begin
         if (folded_q.size() == first) begin
            tail_slot.out_byte    = 8'h00;
            tail_slot.has_byte    = 1'b0;
            tail_slot.last_of_key = 1'b1;
            add_result(tail_slot);
         end else begin
            tail_slot = folded_q[folded_q.size() - 1];
            tail_slot.last_of_key = 1'b1;
            folded_q[folded_q.size() - 1] = tail_slot;
         end
         clear_fold_state();
      end
   endtask

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 40) begin
         $display("ERROR: %s: got byte %02h has %0b last %0b, wanted byte %02h has %0b last %0b",
                  what, got_slot.out_byte, got_slot.has_byte, got_slot.last_of_key,
                  want_slot.out_byte, want_slot.has_byte, want_slot.last_of_key);
      end
   endtask

   // Input transfers are predicted first, then result transfers are checked.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            fold_byte(req_ch.in_byte, req_ch.end_of_string);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            result_count++;
            got_slot.out_byte    = rsp_ch.out_byte;
            got_slot.has_byte    = rsp_ch.has_byte;
            got_slot.last_of_key = rsp_ch.last_of_key;
            if (folded_q.size() == 0) begin
               want_slot = '0;
               report_mismatch("result with nothing expected");
            end else begin
               want_slot = folded_q.pop_front();
               if (got_slot.out_byte !== want_slot.out_byte ||
                   got_slot.has_byte !== want_slot.has_byte ||
                   got_slot.last_of_key !== want_slot.last_of_key) begin
                  report_mismatch("result differs");
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   // Sends one byte; valid stays high after the transfer until the next gap.
   task automatic send_byte(input logic [7:0] b, input logic eos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.in_byte       <= b;
      req_ch.end_of_string <= eos;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      byte_count++;
   endtask

   // Sends the built string with the end mark on its last byte.
   task automatic send_text();
      for (int i = 0; i < text_q.size(); i++) begin
         send_byte(text_q[i], i == text_q.size() - 1);
      end
      string_count++;
   endtask

   // Capitals, Turkish letters, collapsed blanks and an unmatched pair that
   // fills all three result slots.
   task automatic test_case_fold();
      text_q = '{8'h20, 8'h41, 8'hC3, 8'h87, 8'h09, 8'hC4, 8'h5A};
      send_text();
      text_q = '{8'hC4, 8'hB1};
      send_text();
   endtask

   // Field extremes and bytes that cannot start a character.
   task automatic test_invalid_leads();
      text_q = '{8'h00, 8'hFF, 8'h80, 8'h0D};
      send_text();
   endtask

   // Blanks inside a raw character, with a raw space as the final byte.
   task automatic test_raw_sequences();
      text_q = '{8'hE2, 8'h20, 8'h20};
      send_text();
   endtask

   // A held-type lead and a four-byte lead as the final byte.
   task automatic test_lead_at_end();
      text_q = '{utsf_pkg::LEAD_C5};
      send_text();
      text_q = '{8'hF0};
      send_text();
   endtask

   // A string of blanks only gives just the end marker.
   task automatic test_blank_strings();
      text_q = '{utsf_pkg::ASCII_LF, utsf_pkg::ASCII_CR};
      send_text();
   endtask

   // Lead and second byte of one of the twelve Turkish letters, by index.
   function automatic logic [15:0] turkish_pair(input int unsigned idx);
      logic [15:0] p;
      case (idx)
         0:       p = {utsf_pkg::LEAD_C3, 8'h87};
         1:       p = {utsf_pkg::LEAD_C3, 8'hA7};
         2:       p = {utsf_pkg::LEAD_C3, 8'h96};
         3:       p = {utsf_pkg::LEAD_C3, 8'hB6};
         4:       p = {utsf_pkg::LEAD_C3, 8'h9C};
         5:       p = {utsf_pkg::LEAD_C3, 8'hBC};
         6:       p = {utsf_pkg::LEAD_C4, 8'h9E};
         7:       p = {utsf_pkg::LEAD_C4, 8'h9F};
         8:       p = {utsf_pkg::LEAD_C4, 8'hB0};
         9:       p = {utsf_pkg::LEAD_C4, 8'hB1};
         10:      p = {utsf_pkg::LEAD_C5, 8'h9E};
         default: p = {utsf_pkg::LEAD_C5, 8'h9F};
      endcase
      return p;
   endfunction

   // Appends one random character, blank run or piece of noise to the text.
   task automatic add_random_token();
      int unsigned r;
      logic [15:0] pair;
      r = $urandom_range(99);
      if (r < 18) begin
         add_text(8'($urandom_range(utsf_pkg::ASCII_UC_A, utsf_pkg::ASCII_UC_Z)));
      end else if (r < 30) begin
         add_text(8'($urandom_range(8'h61, 8'h7A)));
      end else if (r < 38) begin
         add_text(8'($urandom_range(8'h21, 8'h7F)));
      end else if (r < 52) begin
         repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(3))
               0:       add_text(utsf_pkg::ASCII_SPACE);
               1:       add_text(utsf_pkg::ASCII_TAB);
               2:       add_text(utsf_pkg::ASCII_LF);
               default: add_text(utsf_pkg::ASCII_CR);
            endcase
         end
      end else if (r < 72) begin
         pair = turkish_pair($urandom_range(11));
         add_text(pair[15:8]);
         add_text(pair[7:0]);
      end else if (r < 78) begin
         add_text(8'($urandom_range(8'hC0, 8'hDF)));
         add_text(8'($urandom_range(8'h80, 8'hBF)));
      end else if (r < 83) begin
         add_text(8'($urandom_range(8'hE0, 8'hEF)));
         repeat (2) add_text(8'($urandom_range(8'h80, 8'hBF)));
      end else if (r < 87) begin
         add_text(8'($urandom_range(8'hF0, 8'hF7)));
         repeat (3) add_text(8'($urandom_range(8'h80, 8'hBF)));
      end else if (r < 94) begin
         add_text(8'($urandom_range(0, 255)));
      end else begin
         // Held-type lead followed by an arbitrary byte.
         add_text(8'($urandom_range(utsf_pkg::LEAD_C3, utsf_pkg::LEAD_C5)));
         add_text(8'($urandom_range(0, 255)));
      end
   endtask

   // Random strings under one idling pattern until enough bytes have gone.
   task automatic test_random_text(input int unsigned idle_pct,
                                   input int unsigned stall_pct,
                                   input int unsigned n_bytes);
      int unsigned start;
      int unsigned keep;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      start = byte_count;
      while (byte_count - start < n_bytes) begin
         text_q.delete();
         repeat ($urandom_range(1, 10)) add_random_token();
         // Some strings end in the middle of a character.
         if (text_q.size() > 1 && $urandom_range(9) == 0) begin
            keep = $urandom_range(1, text_q.size());
            while (text_q.size() > keep) text_q.delete(text_q.size() - 1);
         end
         send_text();
      end
   endtask

   // ---------------------------------------------------------------------
   // Run
   // ---------------------------------------------------------------------

   initial begin
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.in_byte       = 8'h00;
      req_ch.end_of_string = 1'b0;
      rsp_ch.ready         = 1'b0;
      send_idle_pct        = 0;
      recv_stall_pct       = 0;
      mismatch_count       = 0;
      byte_count           = 0;
      string_count         = 0;
      result_count         = 0;
      clear_fold_state();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_case_fold();
      test_invalid_leads();
      test_raw_sequences();
      test_lead_at_end();
      test_blank_strings();

      test_random_text(0, 0, 62);
      test_random_text(86, 0, 62);
      test_random_text(0, 86, 62);
      test_random_text(24, 24, 62);
      req_ch.valid <= 1'b0;

      // Drain what is still expected, then allow a few more cycles.
      while (folded_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d strings (%0d bytes) and checked %0d folded results,",
               string_count, byte_count, result_count);
      $display("with no idling, a slow sender, a slow receiver and both.");
      if (mismatch_count == 0 && folded_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Timeout for a hung handshake.
   initial begin
      #600000;
      $display("Mismatches found");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/utsf_pkg.sv
rtl/core/utsf_req_if.sv
rtl/core/utsf_rsp_if.sv
rtl/core/utf8_turkish_search_fold.sv
verif/tb.sv
